// ===== rtl/core/switch_debounce_edge_doubleclick_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the switch debouncer
// Implication checks on a synchronous, active-low reset domain.
// ----------------------------------------------------------------------------
`ifndef SWITCH_DEBOUNCE_EDGE_DOUBLECLICK_MACROS_SVH
`define SWITCH_DEBOUNCE_EDGE_DOUBLECLICK_MACROS_SVH

// same-cycle implication
`define SDE_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SDE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/sde_pkg.sv =====
// ----------------------------------------------------------------------------
// sde_pkg
// Types and constants shared by the switch debouncer modules.
// ----------------------------------------------------------------------------
package sde_pkg;

    localparam logic [1:0] EDGE_NONE = 2'd0;
    localparam logic [1:0] EDGE_FALL = 2'd1;
    localparam logic [1:0] EDGE_RISE = 2'd2;

    localparam logic REG_DEBOUNCE_LIMIT = 1'b0;
    localparam logic REG_CLICK_WINDOW   = 1'b1;

    localparam logic [7:0] DEBOUNCE_LIMIT_RST = 8'd8;
    localparam logic [7:0] CLICK_WINDOW_RST   = 8'd50;

    localparam int RAW_BYTES = 3;

    typedef struct packed {
        logic [7:0] raw_byte_a;
        logic [7:0] raw_byte_b;
        logic [7:0] raw_byte_c;
    } t_in_item;

    typedef struct packed {
        logic [4:0] switch_index;
        logic [1:0] edge_code;
        logic [7:0] click_count;
        logic       last_switch;
    } t_out_item;

    typedef struct packed {
        logic [1:0] edge_code;
        logic [7:0] click_count;
    } t_lane_out;

    typedef enum logic {
        SEQ_IDLE,
        SEQ_EMIT
    } t_seq_state;

endpackage

// ===== rtl/core/switch_debounce_edge_doubleclick.sv =====
// ----------------------------------------------------------------------------
// switch_debounce_edge_doubleclick
// Integrating debouncer with edge detect and click counting, one lane per
// switch; results leave one switch per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
// First result: the input transfer starts the emit state, which loads the
//   output register. A new tick waits for the last result to be loaded; the
//   single result port carries one switch per cycle when not stalled.
// Reset: synchronous; clears every lane, the sequencer and both registers
//   (limit 8, window 50).
module switch_debounce_edge_doubleclick #(
    parameter int NUM_SWITCHES = 24
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  sde_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output sde_pkg::t_out_item o_out_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import sde_pkg::*;

    logic [7:0] r_debounce_limit, n_debounce_limit;
    logic [7:0] r_click_window,   n_click_window;
    logic       w_wr;
    logic [7:0] w_limit;
    logic       w_step;
    logic [7:0] w_bytes [RAW_BYTES];
    t_lane_out  w_lanes [NUM_SWITCHES];

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    always_comb begin
        n_debounce_limit = r_debounce_limit;
        n_click_window   = r_click_window;
        if (w_wr) begin
            case (paddr[2])
                REG_DEBOUNCE_LIMIT: n_debounce_limit = pwdata[7:0];
                REG_CLICK_WINDOW:   n_click_window   = pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_limit <= DEBOUNCE_LIMIT_RST;
            r_click_window   <= CLICK_WINDOW_RST;
        end else begin
            r_debounce_limit <= n_debounce_limit;
            r_click_window   <= n_click_window;
        end
    end

    always_comb begin
        case (paddr[2])
            REG_DEBOUNCE_LIMIT: prdata = {24'd0, r_debounce_limit};
            REG_CLICK_WINDOW:   prdata = {24'd0, r_click_window};
            default:            prdata = 32'd0;
        endcase
    end

    assign w_limit = (r_debounce_limit == 8'd0) ? 8'd1 : r_debounce_limit;

    assign w_bytes[0] = i_in_data.raw_byte_a;
    assign w_bytes[1] = i_in_data.raw_byte_b;
    assign w_bytes[2] = i_in_data.raw_byte_c;

    for (genvar g = 0; g < NUM_SWITCHES; g++) begin : g_lane
        localparam int BI = g / 8;
        localparam int BT = (g % 8) ^ 4;
        logic w_sample;

        if (BI < RAW_BYTES) begin : g_in
            assign w_sample = w_bytes[BI][BT];
        end else begin : g_low
            assign w_sample = 1'b0;
        end

        sde_lane u_lane (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_step   (w_step),
            .i_sample (w_sample),
            .i_limit  (w_limit),
            .i_window (r_click_window),
            .o_lane   (w_lanes[g])
        );
    end

    sde_emit #(
        .NUM_SWITCHES (NUM_SWITCHES)
    ) u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_step      (w_step),
        .i_lanes     (w_lanes),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

// ===== rtl/core/sde_lane.sv =====
// ----------------------------------------------------------------------------
// sde_lane
// One switch: saturating integrator, stable level, edge code and click tally.
// ----------------------------------------------------------------------------
module sde_lane (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic              i_sample,
    input  logic [7:0]        i_limit,
    input  logic [7:0]        i_window,
    output sde_pkg::t_lane_out o_lane
);
    import sde_pkg::*;

    logic [7:0] r_integ, n_integ;
    logic       r_level, n_level;
    logic [1:0] r_code,  n_code;
    logic [7:0] r_tally, n_tally;
    logic [7:0] r_win,   n_win;
    logic       w_edge;
    logic [7:0] w_win_a;

    always_comb begin
        n_integ = r_integ;
        if (i_sample) begin
            if (r_integ < i_limit) begin
                n_integ = r_integ + 8'd1;
            end
        end else if (r_integ != 8'd0) begin
            n_integ = r_integ - 8'd1;
        end

        n_level = r_level;
        n_code  = r_code;
        w_edge  = 1'b0;
        if (n_integ == i_limit) begin
            n_code  = r_level ? EDGE_NONE : EDGE_RISE;
            w_edge  = !r_level;
            n_level = 1'b1;
        end else if (n_integ == 8'd0) begin
            n_code  = r_level ? EDGE_FALL : EDGE_NONE;
            w_edge  = r_level;
            n_level = 1'b0;
        end

        w_win_a = (w_edge && r_win == 8'd0) ? i_window : r_win;
        if (w_win_a != 8'd0) begin
            n_win   = w_win_a - 8'd1;
            n_tally = r_tally + {7'd0, w_edge};
        end else begin
            n_win   = 8'd0;
            n_tally = 8'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ <= '0;
            r_level <= 1'b0;
            r_code  <= EDGE_NONE;
            r_tally <= '0;
            r_win   <= '0;
        end else if (i_step) begin
            r_integ <= n_integ;
            r_level <= n_level;
            r_code  <= n_code;
            r_tally <= n_tally;
            r_win   <= n_win;
        end
    end

    assign o_lane.edge_code   = r_code;
    assign o_lane.click_count = r_tally;

endmodule

// ===== rtl/core/sde_emit.sv =====
// ----------------------------------------------------------------------------
// sde_emit
// Tick sequencer and result merge: steps all lanes, then serialises one
// result per switch through an output register.
// ----------------------------------------------------------------------------
module sde_emit #(
    parameter int NUM_SWITCHES = 24
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output logic               o_step,
    input  sde_pkg::t_lane_out i_lanes [NUM_SWITCHES],
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output sde_pkg::t_out_item o_out_data
);
    import sde_pkg::*;

    localparam int IW = $clog2(NUM_SWITCHES);
    localparam logic [IW-1:0] LAST_IDX = IW'(NUM_SWITCHES - 1);

    t_seq_state r_state, n_state;
    logic [IW-1:0] r_idx, n_idx;
    logic          r_out_valid, n_out_valid;
    t_out_item     r_out_data, n_out_data;
    logic          w_slot_free;
    logic          w_load;
    logic          w_last;

    assign w_slot_free = !r_out_valid || i_out_ready;
    assign w_last      = (r_idx == LAST_IDX);

    always_comb begin
        n_state = r_state;
        case (r_state)
            SEQ_IDLE: begin
                if (i_in_valid) begin
                    n_state = SEQ_EMIT;
                end
            end
            SEQ_EMIT: begin
                if (w_slot_free && w_last) begin
                    n_state = SEQ_IDLE;
                end
            end
            default: n_state = SEQ_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        w_load     = 1'b0;
        case (r_state)
            SEQ_IDLE: o_in_ready = 1'b1;
            SEQ_EMIT: w_load     = w_slot_free;
            default: begin
                o_in_ready = 1'b0;
                w_load     = 1'b0;
            end
        endcase
    end

    assign o_step = o_in_ready && i_in_valid;

    always_comb begin
        n_idx       = r_idx;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_data  = r_out_data;
        if (w_load) begin
            n_idx                    = w_last ? '0 : r_idx + 1'b1;
            n_out_valid              = 1'b1;
            n_out_data.switch_index  = 5'(r_idx);
            n_out_data.edge_code     = i_lanes[r_idx].edge_code;
            n_out_data.click_count   = i_lanes[r_idx].click_count;
            n_out_data.last_switch   = w_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= SEQ_IDLE;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// ===== rtl/core/sde_chk.sv =====
// ----------------------------------------------------------------------------
// sde_chk
// Port-level checks for the switch debouncer, bound to the top level.
// ----------------------------------------------------------------------------
`include "switch_debounce_edge_doubleclick_macros.svh"

module sde_chk #(
    parameter int NUM_SWITCHES = 24
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input sde_pkg::t_out_item o_out_data
);
    import sde_pkg::*;

    localparam logic [4:0] LAST_IDX = 5'(NUM_SWITCHES - 1);

    `SDE_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_data), "result dropped or changed while stalled")
    `SDE_ASSERT_NEXT(a_one_tick, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready, "second tick taken while results pending")
    `SDE_ASSERT_NOW(a_ready_last, i_clk, i_rst_n, o_in_ready && o_out_valid, o_out_data.last_switch, "input ready before final result of tick")
    `SDE_ASSERT_NOW(a_last_idx, i_clk, i_rst_n, o_out_valid && o_out_data.last_switch, o_out_data.switch_index == LAST_IDX, "final flag on wrong switch")

endmodule

bind switch_debounce_edge_doubleclick sde_chk #(
    .NUM_SWITCHES (NUM_SWITCHES)
) u_sde_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: switch debouncer with edge detect and click counting
// Sends ticks of three raw bytes through the input channel and checks each
// per-switch result against a typed row or an in-bench debounce model.
// The run starts with a directed table that covers reset values, extremes,
// nibble swap, zero limit, zero window and a limit lowered below a running
// integrator. It then runs random phases with random register settings.
// Both channels stall at random.
// ----------------------------------------------------------------------------
module tb_top;
    import sde_pkg::*;

    localparam int NUM_SW    = 24;
    localparam int MAX_SHOWN = 10;
    localparam int N_ROWS    = 28;

    typedef enum logic [1:0] {
        ROW_TICK,
        ROW_LIMIT,
        ROW_WINDOW
    } t_row_kind;

    typedef struct packed {
        t_row_kind  kind;
        t_in_item   raw;
        logic       typed;
        logic [1:0] edge_c;
        logic [7:0] clicks;
        logic [7:0] value;
    } t_row;

    // typed rows carry the result that every switch must report
    t_row dir_rows [N_ROWS] = '{
        '{ROW_TICK,   24'h000000, 1'b1, EDGE_NONE, 8'd0, 8'd0},
        '{ROW_TICK,   24'hFFFFFF, 1'b1, EDGE_NONE, 8'd0, 8'd0},
        '{ROW_LIMIT,  24'h000000, 1'b0, EDGE_NONE, 8'd0, 8'd1},
        '{ROW_TICK,   24'hFFFFFF, 1'b1, EDGE_RISE, 8'd1, 8'd0},
        '{ROW_TICK,   24'h000000, 1'b1, EDGE_FALL, 8'd2, 8'd0},
        '{ROW_TICK,   24'h000000, 1'b1, EDGE_NONE, 8'd2, 8'd0},
        '{ROW_TICK,   24'h018010, 1'b0, EDGE_NONE, 8'd0, 8'd0},
        '{ROW_TICK,   24'h800108, 1'b0, EDGE_NONE, 8'd0, 8'd0},
        '{ROW_TICK,   24'hA55AF0, 1'b0, EDGE_NONE, 8'd0, 8'd0},
        '{ROW_TICK,   24'h0FC33C, 1'b0, EDGE_NONE, 8'd0, 8'd0},
        '{ROW_LIMIT,  24'h000000, 1'b0, EDGE_NONE, 8'd0, 8'd0},
        '{ROW_TICK,   24'hFFFFFF, 1'b0, EDGE_NONE, 8'd0, 8'd0},
        '{ROW_TICK,   24'h000000, 1'b0, EDGE_NONE, 8'd0, 8'd0},
        '{ROW_WINDOW, 24'h000000, 1'b0, EDGE_NONE, 8'd0, 8'd0},
        '{ROW_TICK,   24'hFFFFFF, 1'b0, EDGE_NONE, 8'd0, 8'd0},
        '{ROW_TICK,   24'h000000, 1'b0, EDGE_NONE, 8'd0, 8'd0},
        '{ROW_LIMIT,  24'h000000, 1'b0, EDGE_NONE, 8'd0, 8'd255},
        '{ROW_WINDOW, 24'h000000, 1'b0, EDGE_NONE, 8'd0, 8'd255},
        '{ROW_TICK,   24'hFFFFFF, 1'b0, EDGE_NONE, 8'd0, 8'd0},
        '{ROW_TICK,   24'hFFFFFF, 1'b0, EDGE_NONE, 8'd0, 8'd0},
        '{ROW_TICK,   24'hFFFFFF, 1'b0, EDGE_NONE, 8'd0, 8'd0},
        '{ROW_TICK,   24'hFFFFFF, 1'b0, EDGE_NONE, 8'd0, 8'd0},
        '{ROW_LIMIT,  24'h000000, 1'b0, EDGE_NONE, 8'd0, 8'd2},
        '{ROW_TICK,   24'hFFFFFF, 1'b0, EDGE_NONE, 8'd0, 8'd0},
        '{ROW_TICK,   24'h000000, 1'b0, EDGE_NONE, 8'd0, 8'd0},
        '{ROW_TICK,   24'h000000, 1'b0, EDGE_NONE, 8'd0, 8'd0},
        '{ROW_TICK,   24'h000000, 1'b0, EDGE_NONE, 8'd0, 8'd0},
        '{ROW_TICK,   24'h000000, 1'b0, EDGE_NONE, 8'd0, 8'd0}
    };

    logic        i_clk    = 1'b0;
    logic        i_rst_n  = 1'b0;
    logic        in_valid = 1'b0;
    logic        o_in_ready;
    t_in_item    in_data  = '0;
    logic        o_out_valid;
    logic        out_ready = 1'b0;
    t_out_item   o_out_data;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [2:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    // model state
    logic [7:0] limit_cfg;
    logic [7:0] window_cfg;
    logic [7:0] integ_lvl   [NUM_SW];
    logic       stable_lvl  [NUM_SW];
    logic [1:0] edge_held   [NUM_SW];
    logic [7:0] click_tally [NUM_SW];
    logic [7:0] window_left [NUM_SW];
    t_out_item  tick_reports [NUM_SW];

    t_out_item  switch_reports [$];
    t_out_item  want;
    int         fail_count = 0;
    int         stall_left = 0;
    bit         no_idle    = 1'b0;

    switch_debounce_edge_doubleclick #(
        .NUM_SWITCHES(NUM_SW)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(out_ready),
        .o_out_data (o_out_data),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    function automatic void clear_model();
        limit_cfg  = DEBOUNCE_LIMIT_RST;
        window_cfg = CLICK_WINDOW_RST;
        for (int i = 0; i < NUM_SW; i++) begin
            integ_lvl[i]   = '0;
            stable_lvl[i]  = 1'b0;
            edge_held[i]   = EDGE_NONE;
            click_tally[i] = '0;
            window_left[i] = '0;
        end
    endfunction

    // advance every switch by one tick and fill tick_reports
    function automatic void debounce_tick(input t_in_item raw);
        logic [7:0] lim;
        logic [7:0] bytes_in [RAW_BYTES];
        logic       level;
        int         k;
        lim = (limit_cfg == 8'd0) ? 8'd1 : limit_cfg;
        bytes_in[0] = raw.raw_byte_a;
        bytes_in[1] = raw.raw_byte_b;
        bytes_in[2] = raw.raw_byte_c;
        for (int i = 0; i < NUM_SW; i++) begin
            k = i / 8;
            level = (k < RAW_BYTES) ? bytes_in[k][(i % 8) ^ 4] : 1'b0;
            if (level) begin
                if (integ_lvl[i] < lim) integ_lvl[i] = integ_lvl[i] + 8'd1;
            end else if (integ_lvl[i] != 8'd0) begin
                integ_lvl[i] = integ_lvl[i] - 8'd1;
            end
            if (integ_lvl[i] == lim) begin
                if (stable_lvl[i]) begin
                    edge_held[i] = EDGE_NONE;
                end else begin
                    edge_held[i] = EDGE_RISE;
                    click_tally[i] = click_tally[i] + 8'd1;
                    if (window_left[i] == 8'd0) window_left[i] = window_cfg;
                end
                stable_lvl[i] = 1'b1;
            end else if (integ_lvl[i] == 8'd0) begin
                if (stable_lvl[i]) begin
                    edge_held[i] = EDGE_FALL;
                    click_tally[i] = click_tally[i] + 8'd1;
                    if (window_left[i] == 8'd0) window_left[i] = window_cfg;
                end else begin
                    edge_held[i] = EDGE_NONE;
                end
                stable_lvl[i] = 1'b0;
            end
            if (window_left[i] != 8'd0) window_left[i] = window_left[i] - 8'd1;
            else click_tally[i] = 8'd0;
            tick_reports[i] = '{5'(i), edge_held[i], click_tally[i], (i == NUM_SW - 1)};
        end
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 30);
    endfunction

    task automatic drain();
        while (switch_reports.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic reg_sel, input logic [7:0] value);
        in_valid <= 1'b0;
        drain();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= {24'd0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (reg_sel == REG_DEBOUNCE_LIMIT) limit_cfg = value;
        else window_cfg = value;
    endtask

    task automatic send_tick(input t_in_item raw, input logic typed,
                             input logic [1:0] edge_c, input logic [7:0] clicks);
        int gap;
        gap = pick_gap();
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= raw;
        do @(posedge i_clk); while (!o_in_ready);
        debounce_tick(raw);
        for (int i = 0; i < NUM_SW; i++) begin
            if (typed) switch_reports.push_back('{5'(i), edge_c, clicks, (i == NUM_SW - 1)});
            else switch_reports.push_back(tick_reports[i]);
        end
    endtask

    task automatic note_fail(input string what, input t_out_item exp, input t_out_item got);
        fail_count++;
        if (fail_count <= MAX_SHOWN) begin
            $display("%s: want idx %0d edge %0d clicks %0d last %0b, got idx %0d edge %0d clicks %0d last %0b",
                     what, exp.switch_index, exp.edge_code, exp.click_count, exp.last_switch,
                     got.switch_index, got.edge_code, got.click_count, got.last_switch);
        end
    endtask

    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left = stall_left - 1;
            out_ready <= 1'b0;
        end else if (!no_idle && $urandom_range(0, 3) == 0) begin
            stall_left = pick_gap();
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && out_ready) begin
            if (switch_reports.size() == 0) begin
                note_fail("result with nothing pending", '0, o_out_data);
            end else begin
                want = switch_reports.pop_front();
                if (want.switch_index !== o_out_data.switch_index
                    || want.edge_code !== o_out_data.edge_code
                    || want.click_count !== o_out_data.click_count
                    || want.last_switch !== o_out_data.last_switch) begin
                    note_fail("mismatch", want, o_out_data);
                end
            end
        end
    end

    initial begin : stimulus
        t_in_item   pattern;
        logic [7:0] lim_val;
        logic [7:0] win_val;
        int         r;
        clear_model();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int n = 0; n < N_ROWS; n++) begin
            case (dir_rows[n].kind)
                ROW_LIMIT: begin
                    write_reg(REG_DEBOUNCE_LIMIT, dir_rows[n].value);
                end
                ROW_WINDOW: begin
                    write_reg(REG_CLICK_WINDOW, dir_rows[n].value);
                end
                default: begin
                    send_tick(dir_rows[n].raw, dir_rows[n].typed,
                              dir_rows[n].edge_c, dir_rows[n].clicks);
                end
            endcase
        end

        for (int p = 0; p < 6; p++) begin
            case ($urandom_range(0, 9))
                0: lim_val = 8'd0;
                1: lim_val = 8'd255;
                2: lim_val = 8'($urandom_range(4, 30));
                default: lim_val = 8'($urandom_range(1, 3));
            endcase
            case ($urandom_range(0, 5))
                0: win_val = 8'd0;
                1: win_val = 8'd1;
                2: win_val = 8'd255;
                default: win_val = 8'($urandom_range(2, 20));
            endcase
            write_reg(REG_DEBOUNCE_LIMIT, lim_val);
            write_reg(REG_CLICK_WINDOW, win_val);
            no_idle = (p == 2);
            pattern = t_in_item'($urandom);
            for (int n = 0; n < 16; n++) begin
                r = $urandom_range(0, 9);
                // hold a level for a few ticks, with bounces and full flips
                if (r >= 6 && r < 8) pattern = t_in_item'($urandom);
                else if (r == 8) pattern = pattern ^ (24'd1 << $urandom_range(0, 23));
                else if (r == 9) pattern = ~pattern;
                send_tick(pattern, 1'b0, EDGE_NONE, 8'd0);
            end
        end

        in_valid <= 1'b0;
        while (switch_reports.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
        if (fail_count == 0 && switch_reports.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
